FILE: rtl/dbm_pkg.sv
// ----------------------------------------------------------------------------
// dbm_pkg
// Shared types, codes and constants of the DFA byte matcher.
// ----------------------------------------------------------------------------
package dbm_pkg;

	localparam int NUM_STATES_DEF    = 256;
	localparam int POSITION_BITS_DEF = 16;
	localparam int ENTRY_W           = 10;
	localparam int RES_FIFO_DEPTH    = 4;
	localparam logic [7:0] WILDCARD_BYTE = 8'hFF;

	typedef enum logic [1:0] {
		FUNC_WR_TRANS  = 2'd0,
		FUNC_WR_ACCEPT = 2'd1,
		FUNC_DATA      = 2'd2,
		FUNC_END       = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_GOTO = 2'd1,
		KIND_DEAD = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] target;
	} entry_t;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] table_state;
		logic [7:0] key_byte;
		logic [7:0] target_state;
		logic [1:0] entry_kind;
		logic       accept_value;
		logic [7:0] data_byte;
	} req_t;

	typedef struct packed {
		logic        whole_match;
		logic        prefix_match;
		logic [15:0] stop_position;
		logic        stopped_early;
	} res_t;

	// table write request
	typedef struct packed {
		logic       trans_we;
		logic       acc_we;
		logic [7:0] state;
		logic [7:0] key;
		entry_t     entry;
		logic       acc;
	} tbl_wr_t;

	// table lookup request; the wildcard entry is read alongside
	typedef struct packed {
		logic [7:0] state;
		logic [7:0] key;
	} tbl_rd_t;

	typedef struct packed {
		entry_t dir;
		entry_t wild;
		logic   acc;
	} tbl_rsp_t;

	// unknown kinds store as none; dead keeps no target
	function automatic entry_t make_entry(input logic [1:0] kind, input logic [7:0] target);
		entry_t e;
		e = '0;
		unique case (kind)
			KIND_GOTO: begin
				e.kind   = KIND_GOTO;
				e.target = target;
			end
			KIND_DEAD: begin
				e.kind = KIND_DEAD;
			end
			default: begin
				e.kind = KIND_NONE;
			end
		endcase
		return e;
	endfunction

endpackage

FILE: rtl/dfa_byte_matcher_unit.sv
// ----------------------------------------------------------------------------
// dfa_byte_matcher_unit
// Table-driven DFA byte matcher with loadable transition and accept tables.
//
//   channel  signals                      direction  moves
//   config   cfg_we, cfg_wdata            in         start state write
//   request  req_valid/req_ready/req_data in         load, data byte, end
//   result   res_valid/res_ready/res_data out        verdict per string end
//
// One request per cycle while req_ready is high. The transition memory read
// for a byte feeds the next state straight back into the address of the
// following byte, which sustains that rate. A verdict is registered in end_s1
// and then in the result queue before res_valid rises. After reset a clearing
// sweep of all NUM_STATES*256 entries (65536 by default) holds req_ready low.
// Up to four verdicts are buffered; req_ready drops when the buffer could fill.
// ----------------------------------------------------------------------------
module dfa_byte_matcher_unit import dbm_pkg::*; #(
	parameter int NUM_STATES    = NUM_STATES_DEF,
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       req_valid,
	output logic       req_ready,
	input  req_t       req_data,
	output logic       res_valid,
	input  logic       res_ready,
	output res_t       res_data
);

	localparam int PW = (POSITION_BITS < 16) ? POSITION_BITS : 16;

	logic [7:0]    start_q;
	logic [7:0]    cur_q;
	logic          dead_q;
	logic [PW-1:0] pos_q;
	logic [PW-1:0] fail_q;
	logic          pacc_q;
	logic          data_s1;
	logic          end_s1;

	logic [7:0]    cur_n;
	logic          dead_n;
	logic [PW-1:0] pos_n;
	logic [PW-1:0] fail_n;
	logic          pacc_n;

	logic          req_acc;
	logic          tbl_busy;
	logic          fifo_room;
	tbl_wr_t       tbl_wr;
	tbl_rd_t       tbl_rd;
	tbl_rsp_t      tbl_rsp;
	entry_t        sel;
	res_t          res_w;

	assign req_ready = !tbl_busy && fifo_room;
	assign req_acc   = req_valid && req_ready;

	assign tbl_wr.trans_we = req_acc && (req_data.func == FUNC_WR_TRANS);
	assign tbl_wr.acc_we   = req_acc && (req_data.func == FUNC_WR_ACCEPT);
	assign tbl_wr.state    = req_data.table_state;
	assign tbl_wr.key      = req_data.key_byte;
	assign tbl_wr.entry    = make_entry(req_data.entry_kind, req_data.target_state);
	assign tbl_wr.acc      = req_data.accept_value;

	// lookup uses the state after the byte now resolving
	assign tbl_rd.state = cur_n;
	assign tbl_rd.key   = req_data.data_byte;

	dbm_table #(
		.NUM_STATES(NUM_STATES)
	) u_table (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (tbl_wr),
		.rd    (tbl_rd),
		.rsp   (tbl_rsp),
		.busy  (tbl_busy)
	);

	assign sel = (tbl_rsp.dir.kind == KIND_NONE) ? tbl_rsp.wild : tbl_rsp.dir;

	always_comb begin
		cur_n  = cur_q;
		dead_n = dead_q;
		pos_n  = pos_q;
		fail_n = fail_q;
		pacc_n = pacc_q;
		res_w  = '0;
		if (data_s1 && !dead_q) begin
			if (sel.kind == KIND_GOTO) begin
				cur_n = sel.target;
				if (pos_q != '1) begin
					pos_n = pos_q + 1'b1;
				end
			end else begin
				pacc_n = tbl_rsp.acc;
				fail_n = pos_q;
				dead_n = 1'b1;
			end
		end
		if (end_s1) begin
			res_w.whole_match   = !dead_q && tbl_rsp.acc;
			res_w.prefix_match  = dead_q ? pacc_q : tbl_rsp.acc;
			res_w.stop_position = 16'(dead_q ? fail_q : pos_q);
			res_w.stopped_early = dead_q;
			cur_n  = start_q;
			dead_n = 1'b0;
			pos_n  = '0;
			fail_n = '0;
			pacc_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			cur_q   <= '0;
			dead_q  <= 1'b0;
			pos_q   <= '0;
			fail_q  <= '0;
			pacc_q  <= 1'b0;
			data_s1 <= 1'b0;
			end_s1  <= 1'b0;
		end else begin
			dead_q  <= dead_n;
			pos_q   <= pos_n;
			fail_q  <= fail_n;
			pacc_q  <= pacc_n;
			data_s1 <= req_acc && (req_data.func == FUNC_DATA);
			end_s1  <= req_acc && (req_data.func == FUNC_END);
			if (cfg_we) begin
				start_q <= cfg_wdata;
			end
			if (cfg_we && !dead_q && pos_q == '0) begin
				cur_q <= cfg_wdata;
			end else begin
				cur_q <= cur_n;
			end
		end
	end

	dbm_rfifo u_rfifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (end_s1),
		.push_data(res_w),
		.pend     (end_s1),
		.room     (fifo_room),
		.pop_ready(res_ready),
		.valid    (res_valid),
		.data     (res_data)
	);

	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_busy |-> !req_ready)
		else $error("request taken during clearing sweep");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		end_s1 |=> (!dead_q && pos_q == '0 && cur_q == $past(start_q)))
		else $error("string end did not restart matching");

	a_dead_holds: assert property (@(posedge clk) disable iff (!arst_n)
		data_s1 && dead_q |=> dead_q)
		else $error("dead state left by a data byte");

	a_res_shown: assert property (@(posedge clk) disable iff (!arst_n)
		end_s1 |=> res_valid)
		else $error("verdict not queued");

endmodule

FILE: rtl/dbm_table.sv
// ----------------------------------------------------------------------------
// dbm_table
// Transition and accept memories with a clearing sweep after reset.
// ----------------------------------------------------------------------------
module dbm_table import dbm_pkg::*; #(
	parameter int NUM_STATES = NUM_STATES_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  tbl_wr_t  wr,
	input  tbl_rd_t  rd,
	output tbl_rsp_t rsp,
	output logic     busy
);

	localparam int SW    = $clog2(NUM_STATES);
	localparam int SXW   = (SW > 8) ? SW : 8;
	localparam int DEPTH = NUM_STATES * 256;
	localparam int AW    = SW + 8;

	logic [ENTRY_W-1:0] tmem [DEPTH];
	logic               amem [NUM_STATES];

	logic [AW-1:0]      clr_q;
	logic               busy_q;

	logic               t_we;
	logic [AW-1:0]      t_wa;
	logic [ENTRY_W-1:0] t_wd;
	logic               a_we;
	logic [SW-1:0]      a_wa;
	logic               a_wd;

	logic [AW-1:0]      ra_dir;
	logic [AW-1:0]      ra_wild;
	logic [SW-1:0]      ra_acc;

	logic [ENTRY_W-1:0] dir_s1;
	logic [ENTRY_W-1:0] wild_s1;
	logic               acc_s1;
	logic               ok_s1;

	function automatic logic [SW-1:0] st_idx(input logic [7:0] st);
		logic [SXW-1:0] w;
		w = SXW'(st);
		return w[SW-1:0];
	endfunction

	function automatic logic st_ok(input logic [7:0] st);
		return 32'(st) < NUM_STATES;
	endfunction

	always_comb begin
		if (busy_q) begin
			t_we = 1'b1;
			t_wa = clr_q;
			t_wd = '0;
			a_we = 1'b1;
			a_wa = clr_q[AW-1:8];
			a_wd = 1'b0;
		end else begin
			t_we = wr.trans_we && st_ok(wr.state);
			t_wa = {st_idx(wr.state), wr.key};
			t_wd = wr.entry;
			a_we = wr.acc_we && st_ok(wr.state);
			a_wa = st_idx(wr.state);
			a_wd = wr.acc;
		end
	end

	assign ra_dir  = {st_idx(rd.state), rd.key};
	assign ra_wild = {st_idx(rd.state), WILDCARD_BYTE};
	assign ra_acc  = st_idx(rd.state);

	always_ff @(posedge clk) begin
		if (t_we) begin
			tmem[t_wa] <= t_wd;
		end
		if (a_we) begin
			amem[a_wa] <= a_wd;
		end
		dir_s1  <= tmem[ra_dir];
		wild_s1 <= tmem[ra_wild];
		acc_s1  <= amem[ra_acc];
		ok_s1   <= st_ok(rd.state);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_q  <= '0;
		end else if (busy_q) begin
			if (clr_q == AW'(DEPTH - 1)) begin
				busy_q <= 1'b0;
			end
			clr_q <= clr_q + 1'b1;
		end
	end

	// states beyond the table read as no transition and not accepting
	assign rsp.dir  = ok_s1 ? entry_t'(dir_s1) : '0;
	assign rsp.wild = ok_s1 ? entry_t'(wild_s1) : '0;
	assign rsp.acc  = ok_s1 && acc_s1;
	assign busy     = busy_q;

	a_sweep_len: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> $past(clr_q) == AW'(DEPTH - 1))
		else $error("clearing sweep ended early");

	a_no_wr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !(wr.trans_we || wr.acc_we))
		else $error("table write during clearing sweep");

endmodule

FILE: rtl/dbm_rfifo.sv
// ----------------------------------------------------------------------------
// dbm_rfifo
// Small result queue between the match pipeline and the result channel.
// ----------------------------------------------------------------------------
module dbm_rfifo import dbm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_data,
	input  logic pend,
	output logic room,
	input  logic pop_ready,
	output logic valid,
	output res_t data
);

	localparam int PTRW = $clog2(RES_FIFO_DEPTH);
	localparam int CW   = PTRW + 1;

	res_t            mem_q [RES_FIFO_DEPTH];
	logic [PTRW-1:0] wr_ptr_q;
	logic [PTRW-1:0] rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            pop;

	assign valid = cnt_q != '0;
	assign pop   = valid && pop_ready;
	assign data  = mem_q[rd_ptr_q];
	// pend: a result already on its way in
	assign room  = (cnt_q + CW'(pend)) < CW'(RES_FIFO_DEPTH);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> cnt_q < CW'(RES_FIFO_DEPTH))
		else $error("result queue overflow");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(RES_FIFO_DEPTH))
		else $error("result queue count out of range");

endmodule
